FILE: rtl/sfcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcr_pkg
// Shared types, constants and the byte-wide CRC-32 step for the sync-framed
// CRC-32 receiver.
// ----------------------------------------------------------------------------
package sfcr_pkg;

   localparam int unsigned MAX_FRAME = 1024;
   localparam int unsigned POS_W     = $clog2(MAX_FRAME);
   localparam int unsigned LEN_W     = 11;
   localparam int unsigned CRC_W     = 32;
   localparam int unsigned MIN_FRAME = 8;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [7:0]       SYNC0    = 8'hAA;
   localparam logic [7:0]       SYNC1    = 8'h44;
   localparam logic [7:0]       SYNC2    = 8'h12;
   localparam logic [LEN_W-1:0] FRAME_LENGTH_RESET = 11'd104;

   typedef enum logic [1:0] {
      HUNT_SYNC0 = 2'd0,
      HUNT_SYNC1 = 2'd1,
      HUNT_SYNC2 = 2'd2,
      COLLECT    = 2'd3
   } phase_type;

   typedef struct packed {
      logic             valid;
      logic [7:0]       frame_byte;
      logic [POS_W-1:0] byte_index;
      logic             last_byte;
      logic             crc_ok;
      logic [CRC_W-1:0] computed_crc;
   } result_type;

   // reflected crc-32, one byte, unrolled over its eight bits
   function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] b);
      logic [CRC_W-1:0] v;
      v = {24'h0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         if (v[0]) begin
            v = (v >> 1) ^ CRC_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return {8'h0, crc[CRC_W-1:8]} ^ v;
   endfunction

endpackage

FILE: rtl/sfcr_frame_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcr_frame_tracker
// Sync hunt, frame position, running CRC and trailing CRC capture. Gives the
// result for the byte presented in the same cycle and updates on step.
// ----------------------------------------------------------------------------
module sfcr_frame_tracker
   import sfcr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   input  logic [LEN_W-1:0] frame_length,
   output result_type       result
);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CRC_W-1:0] crc_ff, crc_in;
   logic [CRC_W-1:0] rcv_ff, rcv_in;

   logic [LEN_W-1:0] eff_len;
   logic [LEN_W:0]   pos_ext;
   logic [CRC_W-1:0] crc_cont;
   logic [CRC_W-1:0] crc_start;
   logic             is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= HUNT_SYNC0;
         pos_ff   <= '0;
         crc_ff   <= '0;
         rcv_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         rcv_ff   <= rcv_in;
      end
   end

   always_comb begin
      if (frame_length < LEN_W'(MIN_FRAME)) begin
         eff_len = LEN_W'(MIN_FRAME);
      end else if (frame_length > LEN_W'(MAX_FRAME)) begin
         eff_len = LEN_W'(MAX_FRAME);
      end else begin
         eff_len = frame_length;
      end
   end

   assign pos_ext   = (LEN_W + 1)'(pos_ff);
   assign crc_cont  = crc32_byte(crc_ff, rx_byte);
   assign crc_start = crc32_byte('0, rx_byte);
   assign is_last   = (pos_ext + 1'b1) >= (LEN_W + 1)'(eff_len);

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      rcv_in   = rcv_ff;
      result   = '0;
      result.frame_byte = rx_byte;
      case (phase_ff)
         HUNT_SYNC0: begin
            if (rx_byte == SYNC0) begin
               phase_in     = HUNT_SYNC1;
               pos_in       = POS_W'(1);
               crc_in       = crc_start;
               rcv_in       = '0;
               result.valid = 1'b1;
            end
         end
         HUNT_SYNC1, HUNT_SYNC2: begin
            if ((phase_ff == HUNT_SYNC1 && rx_byte == SYNC1) ||
                (phase_ff == HUNT_SYNC2 && rx_byte == SYNC2)) begin
               phase_in          = (phase_ff == HUNT_SYNC1) ? HUNT_SYNC2 : COLLECT;
               pos_in            = (phase_ff == HUNT_SYNC1) ? POS_W'(2) : POS_W'(3);
               crc_in            = crc_cont;
               result.valid      = 1'b1;
               result.byte_index = (phase_ff == HUNT_SYNC1) ? POS_W'(1) : POS_W'(2);
            end else if (rx_byte == SYNC0) begin
               // broken sequence, but the byte itself opens a new attempt
               phase_in     = HUNT_SYNC1;
               pos_in       = POS_W'(1);
               crc_in       = crc_start;
               rcv_in       = '0;
               result.valid = 1'b1;
            end else begin
               phase_in = HUNT_SYNC0;
               pos_in   = '0;
               crc_in   = '0;
               rcv_in   = '0;
            end
         end
         COLLECT: begin
            result.valid      = 1'b1;
            result.byte_index = pos_ff;
            if ((pos_ext + (LEN_W + 1)'(4)) < (LEN_W + 1)'(eff_len)) begin
               crc_in = crc_cont;
            end else begin
               rcv_in = {rx_byte, rcv_ff[CRC_W-1:8]};
            end
            if (is_last) begin
               result.last_byte    = 1'b1;
               result.crc_ok       = (crc_in == rcv_in);
               result.computed_crc = crc_in;
               phase_in = HUNT_SYNC0;
               pos_in   = '0;
               crc_in   = '0;
               rcv_in   = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         default: begin
            phase_in = HUNT_SYNC0;
         end
      endcase
   end

endmodule

FILE: rtl/sync_framed_crc32_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_framed_crc32_receiver_core
// Hunts for the sync bytes AA 44 12, passes on each frame byte with its index
// and checks the reflected CRC-32 carried in the frame's last four bytes.
// ----------------------------------------------------------------------------
// One byte is taken per clock, every clock, when the result side keeps up; a
// byte lands in the input register when accepted and then in the result
// register, which drives rsp_; the byte-wide CRC step sits combinationally
// between those two registers. Bytes that do not match during the sync hunt
// give no result beat. frame_length is to be written through csr_ only while
// idle; the block itself does not enforce this. Values below 8 act as 8 and
// above 1024 as 1024.
module sync_framed_crc32_receiver_core
   import sfcr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_frame_byte,
   output logic [POS_W-1:0] rsp_byte_index,
   output logic             rsp_last_byte,
   output logic             rsp_crc_ok,
   output logic [CRC_W-1:0] rsp_computed_crc,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_frame_length
);

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic [LEN_W-1:0] frame_length_ff;
   result_type       rsp_ff, rsp_in;
   logic             advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         frame_length_ff <= csr_frame_length;
      end
   end

   // result register can take a new beat
   assign advance   = !rsp_ff.valid || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sfcr_frame_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .step         (in_valid_ff && advance),
      .rx_byte      (in_byte_ff),
      .frame_length (frame_length_ff),
      .result       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (advance) begin
         rsp_ff.valid <= in_valid_ff && rsp_in.valid;
      end
      if (advance) begin
         rsp_ff.frame_byte   <= rsp_in.frame_byte;
         rsp_ff.byte_index   <= rsp_in.byte_index;
         rsp_ff.last_byte    <= rsp_in.last_byte;
         rsp_ff.crc_ok       <= rsp_in.crc_ok;
         rsp_ff.computed_crc <= rsp_in.computed_crc;
      end
   end

   assign rsp_valid        = rsp_ff.valid;
   assign rsp_frame_byte   = rsp_ff.frame_byte;
   assign rsp_byte_index   = rsp_ff.byte_index;
   assign rsp_last_byte    = rsp_ff.last_byte;
   assign rsp_crc_ok       = rsp_ff.crc_ok;
   assign rsp_computed_crc = rsp_ff.computed_crc;

   // a frame is never shorter than the minimum length
   a_last_index_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_byte |-> rsp_byte_index >= POS_W'(MIN_FRAME - 1))
      else $error("last byte of frame below minimum index");

   // check fields only carry data on the last beat of a frame
   a_check_fields_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_byte |-> !rsp_crc_ok && rsp_computed_crc == '0)
      else $error("crc fields set on a non-final beat");

   // input side only stalls with a byte held and the result beat blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   // a beat at index zero is always the first sync byte
   a_sync_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_index == POS_W'(0) |-> rsp_frame_byte == SYNC0)
      else $error("index zero beat is not the first sync byte");

endmodule

FILE: sim/tb_sync_framed_crc32_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_framed_crc32_receiver_core
// Self-checking bench for the sync-framed CRC-32 receiver. Byte streams with
// well-formed frames, spoiled CRCs, broken sync attempts and line noise are
// fed through req_, every rsp_ beat is compared against a bit-serial model
// of the sync hunt and the frame CRC, under random bursts and stalls and
// several frame length settings, the clamped extremes among them.
// ----------------------------------------------------------------------------
module tb_sync_framed_crc32_receiver_core
   import sfcr_pkg::*;
();

   // tracks the sync hunt and frame CRC, holds the beats still to come out
   class frame_crc_tracker;
      phase_type        phase;
      int unsigned      pos;
      logic [CRC_W-1:0] run_crc;
      logic [CRC_W-1:0] rx_crc;
      logic [LEN_W-1:0] len_reg;
      result_type       due_beats[$];
      int               errors;
      int               beats_seen;
      int               frames_good;
      int               frames_bad;

      function new();
         len_reg     = FRAME_LENGTH_RESET;
         errors      = 0;
         beats_seen  = 0;
         frames_good = 0;
         frames_bad  = 0;
         restart();
      endfunction

      function void restart();
         phase   = HUNT_SYNC0;
         pos     = 0;
         run_crc = '0;
         rx_crc  = '0;
      endfunction

      // reflected crc, one bit at a time, lsb of the byte first
      function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc, logic [7:0] b);
         logic [CRC_W-1:0] c;
         logic             fb;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
               c = c ^ CRC_POLY;
            end
         end
         return c;
      endfunction

      function void set_length(logic [LEN_W-1:0] v);
         len_reg = v;
      endfunction

      function int unsigned eff_len();
         if (len_reg < MIN_FRAME) return MIN_FRAME;
         if (len_reg > MAX_FRAME) return MAX_FRAME;
         return 32'(len_reg);
      endfunction

      function int pending();
         return due_beats.size();
      endfunction

      function void open_sync(logic [7:0] b);
         result_type r;
         r            = '0;
         r.valid      = 1'b1;
         r.frame_byte = b;
         run_crc      = crc_step('0, b);
         rx_crc       = '0;
         pos          = 1;
         phase        = HUNT_SYNC1;
         due_beats.push_back(r);
      endfunction

      function void note_byte(logic [7:0] b);
         result_type  r;
         int unsigned n;
         r            = '0;
         r.valid      = 1'b1;
         r.frame_byte = b;
         case (phase)
            HUNT_SYNC0: begin
               if (b == SYNC0) open_sync(b);
            end
            HUNT_SYNC1, HUNT_SYNC2: begin
               if (b == ((phase == HUNT_SYNC1) ? SYNC1 : SYNC2)) begin
                  run_crc      = crc_step(run_crc, b);
                  r.byte_index = pos[POS_W-1:0];
                  pos++;
                  phase = (phase == HUNT_SYNC1) ? HUNT_SYNC2 : COLLECT;
                  due_beats.push_back(r);
               end else if (b == SYNC0) begin
                  // broken sync, the breaking byte may open a new attempt
                  open_sync(b);
               end else begin
                  restart();
               end
            end
            default: begin
               n = eff_len();
               if (pos + 4 < n) begin
                  run_crc = crc_step(run_crc, b);
               end else begin
                  rx_crc = {b, rx_crc[CRC_W-1:8]};
               end
               r.byte_index = pos[POS_W-1:0];
               if (pos + 1 >= n) begin
                  r.last_byte    = 1'b1;
                  r.crc_ok       = (run_crc == rx_crc);
                  r.computed_crc = run_crc;
                  if (r.crc_ok) frames_good++;
                  else frames_bad++;
                  restart();
               end else begin
                  pos++;
               end
               due_beats.push_back(r);
            end
         endcase
      endfunction

      function int differs(string name, logic [CRC_W-1:0] want, logic [CRC_W-1:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            return 1;
         end
         return 0;
      endfunction

      function void match_beat(result_type got);
         result_type want;
         int         bad;
         beats_seen++;
         if (due_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none actual byte %h index %0d",
                     $time, got.frame_byte, got.byte_index);
            return;
         end
         want = due_beats.pop_front();
         bad  = differs("frame_byte", CRC_W'(want.frame_byte), CRC_W'(got.frame_byte));
         bad += differs("byte_index", CRC_W'(want.byte_index), CRC_W'(got.byte_index));
         bad += differs("last_byte", CRC_W'(want.last_byte), CRC_W'(got.last_byte));
         bad += differs("crc_ok", CRC_W'(want.crc_ok), CRC_W'(got.crc_ok));
         bad += differs("computed_crc", want.computed_crc, got.computed_crc);
         if (bad != 0) errors++;
      endfunction
   endclass

   typedef enum {FLOW, LIGHT, HEAVY, COMB} stall_mode_type;

   localparam logic [LEN_W-1:0] LEN_PLAN [11] = '{
      11'd9, 11'd8, 11'd13, 11'd3, 11'd16, 11'd27, 11'd64, 11'd104, 11'd2047,
      11'd11, 11'd40
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [7:0]       req_rx_byte;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [7:0]       rsp_frame_byte;
   logic [POS_W-1:0] rsp_byte_index;
   logic             rsp_last_byte;
   logic             rsp_crc_ok;
   logic [CRC_W-1:0] rsp_computed_crc;
   logic             csr_valid;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_frame_length;

   frame_crc_tracker tracker = new();

   int burst_left = 0;
   int bytes_sent = 0;
   int hold_ask   = 0;
   int hold_done  = 0;

   sync_framed_crc32_receiver_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_computed_crc (rsp_computed_crc),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_frame_length (csr_frame_length)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // watch all three channels at the edge where beats are taken
   always @(posedge clock) begin : watch
      result_type seen;
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.set_length(csr_frame_length);
         if (req_valid && !req_stall) tracker.note_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            seen              = '0;
            seen.valid        = 1'b1;
            seen.frame_byte   = rsp_frame_byte;
            seen.byte_index   = rsp_byte_index;
            seen.last_byte    = rsp_last_byte;
            seen.crc_ok       = rsp_crc_ok;
            seen.computed_crc = rsp_computed_crc;
            tracker.match_beat(seen);
         end
      end
   end

   // result side back-pressure, with a long hold-off on request
   initial begin : rsp_pattern
      stall_mode_type mode;
      int             left;
      int             hold_left;
      int unsigned    tick;
      mode      = FLOW;
      left      = 0;
      hold_left = 0;
      tick      = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_done != hold_ask) begin
            hold_done = hold_ask;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               left = $urandom_range(20, 150);
            end
            left--;
            case (mode)
               FLOW:    rsp_stall <= 1'b0;
               LIGHT:   rsp_stall <= ($urandom_range(0, 3) == 0);
               HEAVY:   rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (tick % 3 == 0);
            endcase
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic write_frame_length(input logic [LEN_W-1:0] v);
      csr_valid        <= 1'b1;
      csr_frame_length <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // let every expected beat come out, then wait out hunt bytes still in flight
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // sync, random body, little-endian crc; spoil flips one bit after the sync
   task automatic send_frame(input int unsigned n, input bit spoil);
      logic [7:0]       fr [];
      logic [CRC_W-1:0] crc;
      int unsigned      k;
      fr    = new[n];
      fr[0] = SYNC0;
      fr[1] = SYNC1;
      fr[2] = SYNC2;
      for (int i = 3; i < n - 4; i++) fr[i] = $urandom_range(0, 255);
      crc = '0;
      for (int i = 0; i < n - 4; i++) crc = tracker.crc_step(crc, fr[i]);
      for (int i = 0; i < 4; i++) fr[n - 4 + i] = crc[8*i +: 8];
      if (spoil) begin
         k     = $urandom_range(3, n - 1);
         fr[k] = fr[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      foreach (fr[i]) push_byte(fr[i]);
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: repeat ($urandom_range(1, 6)) push_byte($urandom_range(0, 255));
         1: begin
            push_byte(SYNC0);
            push_byte($urandom_range(0, 255));
         end
         default: begin
            push_byte(SYNC0);
            push_byte(SYNC1);
            push_byte($urandom_range(0, 255));
         end
      endcase
   endtask

   initial begin : stimulus
      int unsigned n;
      int unsigned body;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_rx_byte      <= '0;
      csr_valid        <= 1'b0;
      csr_frame_length <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_frame_length(11'd8);
      // hunt ignores anything but the first sync byte
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(SYNC1);
      push_byte(SYNC2);
      // sync broken after one and after two bytes, dropped
      push_byte(SYNC0);
      push_byte(8'h13);
      push_byte(SYNC0);
      push_byte(SYNC1);
      push_byte(8'h13);
      // sync broken by a new first sync byte
      push_byte(SYNC0);
      push_byte(SYNC1);
      send_frame(8, 1'b0);
      send_frame(8, 1'b1);
      settle();

      // shorten mid-frame below the current position, also below the minimum
      write_frame_length(11'd1024);
      push_byte(SYNC0);
      push_byte(SYNC1);
      push_byte(SYNC2);
      repeat (9) push_byte($urandom_range(0, 255));
      settle();
      write_frame_length(11'd0);
      push_byte($urandom_range(0, 255));

      foreach (LEN_PLAN[p]) begin
         settle();
         write_frame_length(LEN_PLAN[p]);
         n = (LEN_PLAN[p] < MIN_FRAME) ? MIN_FRAME :
             (LEN_PLAN[p] > MAX_FRAME) ? MAX_FRAME : LEN_PLAN[p];
         if (p == 2 || p == 8) hold_ask++;
         body = 0;
         while (body < 40) begin
            if ($urandom_range(0, 3) == 0) send_noise();
            send_frame(n, $urandom_range(0, 4) == 0);
            body += n;
         end
      end

      settle();
      repeat (8) @(posedge clock);
      $display("run covered %0d input bytes and %0d result beats over %0d length settings",
               bytes_sent, tracker.beats_seen, $size(LEN_PLAN) + 3);
      $display("frames closed with crc match: %0d, with crc mismatch: %0d",
               tracker.frames_good, tracker.frames_bad);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
